// ===== rtl/uartrx_pkg.sv =====
// shared types and constants for the edge-timestamp uart receiver
`timescale 1ns / 1ps
package uartrx_pkg;

	// frame layout: start bit, eight data bits, stop bit
	localparam int unsigned FRAME_BITS = 10;
	localparam int unsigned CNT_W      = 4;
	localparam int unsigned BT_W       = 16;
	localparam logic [BT_W-1:0] BT_RESET = 16'd98;

	// event kinds carried on the input tuser
	localparam logic REQ_EDGE    = 1'b0;
	localparam logic REQ_TIMEOUT = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIV   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	// request to the bounded divide unit
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] limit;
	} div_req_t;

	// answer from the bounded divide unit
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/uartrx_div.sv =====
// bounded iterative divide: one compare-subtract per cycle, quotient capped at a limit
`timescale 1ns / 1ps
module uartrx_div #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  uartrx_pkg::div_req_t    req,
	input  logic [TIME_WIDTH-1:0]   dividend,
	input  logic [TIME_WIDTH-1:0]   divisor,
	output uartrx_pkg::div_rsp_t    rsp
);

	logic [TIME_WIDTH-1:0]        rem_q;
	logic [uartrx_pkg::CNT_W-1:0] cnt_q;
	logic [uartrx_pkg::CNT_W-1:0] limit_q;
	logic                         run_q;
	logic                         done_q;
	logic                         fits;

	// shared compare unit
	assign fits = (rem_q >= divisor) && (cnt_q < limit_q);

	// payload: remainder and limit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q   <= dividend;
			limit_q <= req.limit;
		end else if (run_q && fits) begin
			rem_q <= rem_q - divisor;
		end
	end

	// control: run flag, quotient count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (fits) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = cnt_q;

endmodule

// ===== rtl/uart_rx_edge_timestamp_deframer.sv =====
// top level: 8n1 uart frame decoder fed by line-edge timestamps
`timescale 1ns / 1ps
// Decodes 8N1 UART frames from edge events (s_tuser 0, s_tdata = level after the edge and its
// timestamp) and idle-timeout events (s_tuser 1). Each frame gives one transfer on the master
// side: the data byte and, on m_tuser, 1 for a good stop bit or 0 for a framing error. An edge
// event goes through ST_DIV and then ST_APPLY before s_tready returns; in ST_DIV a single
// compare-subtract unit counts whole bit times (at most 10) in the gap since the previous edge,
// taking off one bit time per cycle. A timeout goes through ST_APPLY while a frame is open and
// is dropped while hunting. s_tready is low while an item is being worked and while a finished
// byte waits for a free output register. bit_time is written through cfg_we / cfg_wdata (zero
// counts as one tick); the user must write it only while idle, the block does not enforce it.
module uart_rx_edge_timestamp_deframer #(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,  // bit_time
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // [0] line_level, [32:1] timestamp, [39:33] zero
	input  logic        s_tuser,    // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] data_byte
	output logic        m_tuser     // [0] frame_ok
);

	localparam int unsigned TS_W = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
	localparam int unsigned FB   = uartrx_pkg::FRAME_BITS;
	localparam int unsigned CW   = uartrx_pkg::CNT_W;

	uartrx_pkg::state_t          state_q;
	logic [uartrx_pkg::BT_W-1:0] bt_q;
	logic                        hunting_q;
	logic                        after_good_q;
	logic [TIME_WIDTH-1:0]       last_q;
	logic [FB-1:0]               frame_q;
	logic [CW-1:0]               bits_q;
	logic [TIME_WIDTH-1:0]       ts_q;
	logic                        timeout_q;
	logic                        falling_q;
	logic                        m_tvalid_q;
	logic [7:0]                  m_tdata_q;
	logic                        m_tuser_q;

	logic                        accept;
	logic [TIME_WIDTH-1:0]       ts_in;
	logic [TIME_WIDTH-1:0]       gap;
	logic [TIME_WIDTH-1:0]       divisor;
	logic [uartrx_pkg::BT_W-1:0] eff_bt;
	uartrx_pkg::div_req_t        div_req;
	uartrx_pkg::div_rsp_t        div_rsp;
	logic [CW-1:0]               room;
	logic [CW-1:0]               nfill;
	logic [CW-1:0]               new_bits;
	logic [FB-1:0]               fill_mask;
	logic [FB-1:0]               new_frame;
	logic                        frame_done;
	logic                        out_free;
	logic                        apply_go;
	logic                        frame_ok;

	assign ts_in   = TIME_WIDTH'(s_tdata[TS_W:1]);
	assign gap     = ts_in - last_q;
	assign eff_bt  = (bt_q == '0) ? uartrx_pkg::BT_W'(1) : bt_q;
	assign divisor = TIME_WIDTH'(eff_bt);
	assign room    = CW'(FB) - bits_q;

	assign s_tready = (state_q == uartrx_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// start the bit count for every edge; hunting only asks whether one bit time has passed
	always_comb begin
		div_req.start = accept && (s_tuser == uartrx_pkg::REQ_EDGE);
		div_req.limit = hunting_q ? CW'(1) : room;
	end

	uartrx_div #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (gap),
		.divisor  (divisor),
		.rsp      (div_rsp)
	);

	// bits added by this event and the frame they give
	always_comb begin
		nfill = timeout_q ? room : div_rsp.quot;
		for (int i = 0; i < FB; i++) begin
			fill_mask[i] = (CW'(i) >= bits_q) && ({1'b0, CW'(i)} < ({1'b0, bits_q} + {1'b0, nfill}));
		end
		new_frame  = (timeout_q || falling_q) ? (frame_q | fill_mask) : frame_q;
		new_bits   = bits_q + nfill;
		frame_done = !hunting_q && (new_bits >= CW'(FB));
		frame_ok   = new_frame[FB-1];
		apply_go   = (state_q == uartrx_pkg::ST_APPLY) && (!frame_done || out_free);
	end

	// event latch
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q      <= ts_in;
			timeout_q <= s_tuser;
			falling_q <= !s_tdata[0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uartrx_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				uartrx_pkg::ST_IDLE: begin
					if (accept) begin
						if (s_tuser == uartrx_pkg::REQ_EDGE) begin
							state_q <= uartrx_pkg::ST_DIV;
						end else if (!hunting_q) begin
							state_q <= uartrx_pkg::ST_APPLY;
						end
					end
				end
				uartrx_pkg::ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= uartrx_pkg::ST_APPLY;
					end
				end
				uartrx_pkg::ST_APPLY: begin
					if (apply_go) begin
						state_q <= uartrx_pkg::ST_IDLE;
					end
				end
				default: state_q <= uartrx_pkg::ST_IDLE;
			endcase
		end
	end

	// receiver state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_q         <= uartrx_pkg::BT_RESET;
			hunting_q    <= 1'b1;
			after_good_q <= 1'b1;
			last_q       <= '0;
			frame_q      <= '0;
			bits_q       <= '0;
		end else begin
			if (cfg_we) begin
				bt_q <= cfg_wdata;
			end
			if (apply_go) begin
				if (!timeout_q) begin
					last_q <= ts_q;
				end
				if (hunting_q) begin
					// falling edge after idle or straight after a good frame opens a frame
					if (falling_q && (div_rsp.quot != '0 || after_good_q)) begin
						hunting_q    <= 1'b0;
						after_good_q <= 1'b0;
						frame_q      <= '0;
						bits_q       <= '0;
					end
				end else if (frame_done) begin
					frame_q <= '0;
					bits_q  <= '0;
					if (frame_ok && falling_q && !timeout_q) begin
						hunting_q    <= 1'b0;
						after_good_q <= 1'b0;
					end else begin
						hunting_q    <= 1'b1;
						after_good_q <= frame_ok;
					end
				end else begin
					frame_q <= new_frame;
					bits_q  <= new_bits;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (apply_go && frame_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go && frame_done) begin
			m_tdata_q <= new_frame[8:1];
			m_tuser_q <= frame_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== tb/sv/uartrx_frame_monitor.sv =====
// frame monitor: decodes accepted edge and timeout events and checks the byte results of the uart deframer
`timescale 1ns / 1ps
module uartrx_frame_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,    // [0] line_level, [32:1] timestamp, [39:33] zero
	input  logic        s_tuser,    // [0] req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,    // [7:0] data_byte
	input  logic        m_tuser,    // [0] frame_ok
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] data_b;
		logic       ok;
	} frame_res_t;

	// decoder state, mirrors the block
	logic [uartrx_pkg::BT_W-1:0] bit_time;
	logic                        hunt;
	logic [31:0]                 prev_t;
	logic                        after_ok;
	logic [9:0]                  frame_bits;
	int unsigned                 bits_held;

	frame_res_t due_frames[$];
	frame_res_t oldest;

	task automatic open_frame();
		hunt       = 1'b0;
		after_ok   = 1'b0;
		frame_bits = '0;
		bits_held  = 0;
	endtask

	// ten bits in: queue the byte and stop-bit flag, then hunt or chain into the next frame
	task automatic close_frame(input logic by_fall);
		frame_res_t res;
		res.data_b = frame_bits[8:1];
		res.ok     = frame_bits[9];
		due_frames.push_back(res);
		if (res.ok && by_fall) begin
			open_frame();
		end else begin
			hunt       = 1'b1;
			after_ok   = res.ok;
			frame_bits = '0;
			bits_held  = 0;
		end
	endtask

	// one accepted event: edge or idle timeout
	task automatic decode_event(input logic req, input logic lvl, input logic [31:0] ts);
		logic [31:0] gap;
		logic [31:0] step_t;
		logic [31:0] nb;
		logic [31:0] fill;
		int unsigned roomv;
		gap    = ts - prev_t;
		step_t = (bit_time == '0) ? 32'd1 : {16'd0, bit_time};
		roomv  = uartrx_pkg::FRAME_BITS - bits_held;
		if (hunt) begin
			// timeouts are ignored while hunting
			if (req == uartrx_pkg::REQ_EDGE) begin
				if (lvl == 1'b0 && (gap >= step_t || after_ok))
					open_frame();
				prev_t = ts;
			end
		end else if (req == uartrx_pkg::REQ_TIMEOUT) begin
			// idle line: the rest of the frame reads as ones, edge time kept
			fill       = ((32'd1 << roomv) - 32'd1) << bits_held;
			frame_bits = frame_bits | fill[9:0];
			bits_held  = uartrx_pkg::FRAME_BITS;
			close_frame(1'b0);
		end else begin
			// whole bit times since the last edge, held to the room left
			nb = gap / step_t;
			if (nb > roomv)
				nb = roomv;
			prev_t = ts;
			if (lvl == 1'b0) begin
				fill       = ((32'd1 << nb) - 32'd1) << bits_held;
				frame_bits = frame_bits | fill[9:0];
			end
			bits_held = bits_held + nb;
			if (bits_held >= uartrx_pkg::FRAME_BITS)
				close_frame(lvl == 1'b0);
		end
	endtask

	// check results first, then register writes and new events of this edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time   = uartrx_pkg::BT_RESET;
			hunt       = 1'b1;
			prev_t     = '0;
			after_ok   = 1'b1;
			frame_bits = '0;
			bits_held  = 0;
			due_frames.delete();
			pending    = 0;
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_frames.size() == 0) begin
					$error("frame result with none expected: data_byte %02h frame_ok %0b",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					oldest = due_frames.pop_front();
					if (m_tdata !== oldest.data_b) begin
						$error("data_byte: expected %02h, got %02h", oldest.data_b, m_tdata);
						fail_count++;
					end
					if (m_tuser !== oldest.ok) begin
						$error("frame_ok: expected %0b, got %0b", oldest.ok, m_tuser);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				bit_time = cfg_wdata;
			if (s_tvalid && s_tready)
				decode_event(s_tuser, s_tdata[0], s_tdata[32:1]);
			pending = due_frames.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: event stimulus, handshake pacing and verdict for the uart deframer
`timescale 1ns / 1ps
module tb;

	localparam int STALL_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 180;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [0] line_level, [32:1] timestamp, [39:33] zero
	logic        s_tuser;   // [0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] data_byte
	logic        m_tuser;   // [0] frame_ok
	int          fail_count;
	int          pending;

	// pacing and line timing
	int          tx_idle_pct;
	int          rx_stall_pct;
	logic        hold_req;
	int          quiet_cycles;
	int          items_sent;
	logic [31:0] line_t;
	int unsigned period;
	int unsigned jit;

	uart_rx_edge_timestamp_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	uartrx_frame_monitor u_frame_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, plus one long hold on request
	initial begin
		logic hold_seen;
		hold_seen = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// real bit period a little over the programmed bit time, with small edge jitter
	function automatic void set_timing(input logic [15:0] bt);
		int unsigned bt_eff;
		bt_eff = (bt == '0) ? 1 : bt;
		period = bt_eff + bt_eff / 20;
		jit    = bt_eff / 40;
	endfunction

	function automatic int jitter();
		return (jit == 0) ? 0 : int'($urandom_range(2 * jit)) - int'(jit);
	endfunction

	// offer one event and wait for its transfer
	task automatic send_item(input logic req, input logic lvl, input logic [31:0] ts);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'd0, ts, lvl};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (req == uartrx_pkg::REQ_EDGE)
			line_t = ts;
		items_sent++;
		@(negedge clk);
	endtask

	// stop offering until every expected frame has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_bit_time(input logic [15:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		set_timing(v);
	endtask

	// one 8n1 frame as line edges: start edge, a transfer per level change, closing rise
	task automatic send_frame(input logic [7:0] d, input logic stop, input logic [31:0] t0);
		logic [9:0] lv;
		lv = {stop, d, 1'b0};
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, t0);
		for (int k = 1; k < 10; k++) begin
			if (lv[k] != lv[k-1])
				send_item(uartrx_pkg::REQ_EDGE, lv[k], t0 + k * period + jitter());
		end
		if (!stop)
			send_item(uartrx_pkg::REQ_EDGE, 1'b1, t0 + 10 * period + jitter());
	endtask

	task automatic directed_checks();
		logic [31:0] t0;
		// timeout and rising edge while hunting
		send_item(uartrx_pkg::REQ_TIMEOUT, 1'b1, 32'h0);
		send_item(uartrx_pkg::REQ_EDGE, 1'b1, 32'hFFFF_FFF0);
		// short-gap start right after reset, frame across the timestamp wrap
		t0 = 32'hFFFF_FFF8;
		send_frame(8'h00, 1'b1, t0);
		// falling edge in the stop bit closes the frame and starts the next
		t0 = t0 + 10 * period;
		send_frame(8'hFF, 1'b1, t0);
		// timeout while collecting fills with ones
		send_item(uartrx_pkg::REQ_TIMEOUT, 1'b0, 32'h1234_5678);
		// framing error
		send_frame(8'h00, 1'b0, line_t + 3 * period);
		// short-gap falling edge after a framing error must not start a frame
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, line_t + 5);
		send_item(uartrx_pkg::REQ_EDGE, 1'b1, line_t + 3);
		// start after idle, then an edge shorter than a bit
		t0 = line_t + 2 * period;
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, t0);
		send_item(uartrx_pkg::REQ_EDGE, 1'b1, t0 + 10);
		send_item(uartrx_pkg::REQ_EDGE, 1'b1, line_t + 3 * period);
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, line_t + 4 * period);
		send_item(uartrx_pkg::REQ_TIMEOUT, 1'b1, 32'hFFFF_FFFF);
		// all-ones timestamp, wrap to zero, gap far beyond a frame
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, 32'hFFFF_FFFF);
		send_item(uartrx_pkg::REQ_EDGE, 1'b1, 32'h0);
		send_item(uartrx_pkg::REQ_EDGE, 1'b0, 32'h7FFF_FFFF);
		send_item(uartrx_pkg::REQ_TIMEOUT, 1'b0, 32'h0);
	endtask

	// mostly clean frames with random bytes, some cut-short frames and stray events
	task automatic random_traffic(input int n, input logic with_hold, input logic with_pause);
		int          start_cnt;
		int          r;
		logic [31:0] t0;
		logic        chained;
		logic        hold_done;
		logic        pause_done;
		logic [7:0]  d;
		logic        stop;
		start_cnt  = items_sent;
		chained    = 1'b0;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		t0         = line_t;
		while (items_sent - start_cnt < n) begin
			if (with_hold && !hold_done && items_sent - start_cnt >= n / 3) begin
				hold_req  = 1'b1;
				hold_done = 1'b1;
			end
			if (with_pause && !pause_done && items_sent - start_cnt >= n / 2) begin
				wait_drained();
				pause_done = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 75) begin
				d    = 8'($urandom);
				stop = ($urandom_range(7) != 0);
				if (chained && $urandom_range(1) == 1) begin
					t0 = t0 + 10 * period + jitter();
				end else begin
					if ($urandom_range(1) == 1)
						send_item(uartrx_pkg::REQ_TIMEOUT, 1'($urandom), $urandom);
					t0 = line_t + (1 + $urandom_range(12)) * period + jitter();
				end
				send_frame(d, stop, t0);
				chained = stop;
			end else if (r < 88) begin
				// start bit followed by a few edges at odd times
				t0 = line_t + (2 + $urandom_range(5)) * period;
				send_item(uartrx_pkg::REQ_EDGE, 1'b0, t0);
				repeat ($urandom_range(3, 1))
					send_item(uartrx_pkg::REQ_EDGE, 1'($urandom),
						line_t + $urandom_range(4 * period));
				if ($urandom_range(1) == 1)
					send_item(uartrx_pkg::REQ_TIMEOUT, 1'($urandom), $urandom);
				chained = 1'b0;
			end else begin
				case ($urandom_range(3))
					0: send_item(uartrx_pkg::REQ_EDGE, 1'($urandom),
						line_t + $urandom_range(period / 2));
					1: send_item(uartrx_pkg::REQ_EDGE, 1'($urandom),
						line_t + $urandom_range(12 * period));
					2: send_item(uartrx_pkg::REQ_EDGE, 1'($urandom), $urandom);
					default: send_item(uartrx_pkg::REQ_TIMEOUT, 1'($urandom), $urandom);
				endcase
				chained = 1'b0;
			end
		end
	endtask

	// reset, directed events, then phases over bit times and pacing
	initial begin
		logic [15:0] bt_v;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = uartrx_pkg::REQ_EDGE;
		hold_req     = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		items_sent   = 0;
		line_t       = '0;
		set_timing(uartrx_pkg::BT_RESET);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		directed_checks();

		for (int p = 0; p < 7; p++) begin
			case (p)
				0: begin bt_v = 16'd1;     tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin bt_v = 16'hFFFF;  tx_idle_pct = 61; rx_stall_pct = 0;  end
				2: begin bt_v = 16'd0;     tx_idle_pct = 0;  rx_stall_pct = 61; end
				3: begin
					bt_v = uartrx_pkg::BT_RESET; tx_idle_pct = 7; rx_stall_pct = 7;
				end
				4: begin
					bt_v = 16'($urandom_range(3000, 2)); tx_idle_pct = 61; rx_stall_pct = 0;
				end
				5: begin bt_v = 16'd12;    tx_idle_pct = 0;  rx_stall_pct = 61; end
				default: begin
					bt_v = 16'($urandom_range(700, 2)); tx_idle_pct = 0; rx_stall_pct = 0;
				end
			endcase
			write_bit_time(bt_v);
			line_t = $urandom;
			random_traffic(PHASE_ITEMS, p == 5, p == 6);
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
